@@ hdl/ipvr_pkg.sv @@
// ----------------------------------------------------------------------------
// ipvr_pkg
// Shared types and constants of the recency replacement unit: field widths,
// event codes and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package ipvr_pkg;

  // default number of ways in the set
  localparam int WAYS_DEF = 8;

  // fixed field widths
  localparam int OP_W      = 2;
  localparam int WAY_W     = 3;
  localparam int VEC_W     = 24;
  localparam int VEC_ENT_W = 3;
  localparam int VEC_ENTS  = 8;
  localparam int INS_W     = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = VEC_W;

  // number of sets held in the state RAM
  localparam int SET_DEPTH = 1;

  // event kinds; the fourth code means nothing and leaves the state alone
  typedef enum logic [OP_W-1:0] {
    OP_HIT  = 2'd0,
    OP_FILL = 2'd1,
    OP_INV  = 2'd2
  } op_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROMO = 1'b0,
    CFG_INS   = 1'b1
  } cfg_idx_t;

endpackage

`default_nettype wire

@@ hdl/ipvr_in_if.sv @@
// ----------------------------------------------------------------------------
// ipvr_in_if
// Event channel: valid/ready handshake carrying the event kind and its way.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipvr_in_if;
  logic                        valid;
  logic                        ready;
  logic [ipvr_pkg::OP_W-1:0]   op;
  logic [ipvr_pkg::WAY_W-1:0]  way;

  modport source (output valid, output op, output way, input ready);
  modport sink   (input valid, input op, input way, output ready);
endinterface

`default_nettype wire

@@ hdl/ipvr_out_if.sv @@
// ----------------------------------------------------------------------------
// ipvr_out_if
// Victim channel: valid/ready handshake carrying the next victim way.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipvr_out_if;
  logic                        valid;
  logic                        ready;
  logic [ipvr_pkg::WAY_W-1:0]  victim_way;
  logic                        victim_is_free;

  modport source (output valid, output victim_way, output victim_is_free, input ready);
  modport sink   (input valid, input victim_way, input victim_is_free, output ready);
endinterface

`default_nettype wire

@@ hdl/ipvr_ram.sv @@
// ----------------------------------------------------------------------------
// ipvr_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ipvr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic                 re,
  input  wire logic [AW-1:0]        raddr,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, then registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/ipv_recency_replacement_unit.sv @@
// ----------------------------------------------------------------------------
// ipv_recency_replacement_unit
// Recency replacement state of one cache set with a programmable promotion
// vector and insertion position; reports the next victim after every event.
// ----------------------------------------------------------------------------
// The positions and valid marks of all ways sit in one word of a RAM with a
// registered read. An event is taken when in_chan.ready is high; the set word
// is read on that edge, updated and written back in the next cycle, and the
// victim is chosen from the new state in the cycle after, which loads the
// result register and may take the next event at the same time. So a new
// event is not taken until the set word of the last one is written back. A
// stalled result holds the unit in its victim cycle until the word is taken.
// Configuration writes land at once and are meant for idle periods.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv_recency_replacement_unit #(
  parameter int WAYS = ipvr_pkg::WAYS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  ipvr_in_if.sink                              in_chan,
  ipvr_out_if.source                           out_chan,
  input  wire logic                            cfg_we,
  input  wire logic [ipvr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [ipvr_pkg::CFG_DAT_W-1:0]  cfg_wdata
);

  localparam int PW     = $clog2(WAYS);
  localparam int MAXP   = WAYS - 1;
  localparam int WORD_W = WAYS * (PW + 1);
  localparam int AW     = (ipvr_pkg::SET_DEPTH > 1) ? $clog2(ipvr_pkg::SET_DEPTH) : 1;

  typedef logic [PW-1:0] pos_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_UPD  = 3'b010,
    S_VIC  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [ipvr_pkg::VEC_W-1:0] promo_r;
  logic [ipvr_pkg::INS_W-1:0] ins_r;
  logic                       init_r;

  logic [ipvr_pkg::OP_W-1:0]  op_r;
  logic [ipvr_pkg::WAY_W-1:0] way_r;

  logic [WORD_W-1:0] rdata, wdata;
  logic              accept, slot_free, mem_we;

  pos_t pos_cur [WAYS];
  logic [WAYS-1:0] vld_cur;
  pos_t pos_nxt [WAYS];
  logic [WAYS-1:0] vld_nxt;
  pos_t pos_r   [WAYS];
  logic [WAYS-1:0] vld_r;

  pos_t p, n, ins;
  logic [PW-1:0] widx;
  logic [ipvr_pkg::VEC_ENT_W-1:0] k, vent;
  logic in_range;

  logic [ipvr_pkg::WAY_W-1:0] victim;
  logic                       victim_free;
  logic                       out_valid_r;
  logic [ipvr_pkg::WAY_W-1:0] out_way_r;
  logic                       out_free_r;

  // handshake
  assign slot_free     = !out_valid_r || out_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE) || ((state_r == S_VIC) && slot_free);
  assign accept        = in_chan.valid && in_chan.ready;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_UPD;
      end
      S_UPD: begin
        state_nxt = S_VIC;
      end
      S_VIC: begin
        if (slot_free) state_nxt = accept ? S_UPD : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      promo_r <= '0;
      ins_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        ipvr_pkg::CFG_PROMO: promo_r <= cfg_wdata;
        ipvr_pkg::CFG_INS:   ins_r   <= cfg_wdata[ipvr_pkg::INS_W-1:0];
        default: ;
      endcase
    end
  end

  // hold the event while the set word is fetched
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_chan.op;
      way_r <= in_chan.way;
    end
  end

  // set word store; its contents are masked to zero until first written
  assign mem_we = (state_r == S_UPD);

  ipvr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ipvr_pkg::SET_DEPTH)
  ) u_set_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(0)),
    .wdata (wdata),
    .re    (accept),
    .raddr (AW'(0)),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= 1'b0;
    end else if (mem_we) begin
      init_r <= 1'b1;
    end
  end

  // unpack the set word
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      vld_cur[i] = init_r & rdata[WAYS*PW + i];
      pos_cur[i] = init_r ? rdata[i*PW +: PW] : '0;
    end
  end

  // promotion target and insertion position, saturated to the deepest slot
  assign widx     = PW'(way_r);
  assign in_range = (int'(way_r) < WAYS);
  assign p        = pos_cur[widx];
  assign k        = (int'(p) > ipvr_pkg::VEC_ENTS - 1) ?
                    ipvr_pkg::VEC_ENT_W'(ipvr_pkg::VEC_ENTS - 1) : ipvr_pkg::VEC_ENT_W'(p);
  assign vent     = promo_r[k*ipvr_pkg::VEC_ENT_W +: ipvr_pkg::VEC_ENT_W];
  assign n        = (int'(vent) > MAXP) ? PW'(MAXP) : PW'(vent);
  assign ins      = (int'(ins_r) > MAXP) ? PW'(MAXP) : PW'(ins_r);

  // apply the event to every way at once
  always_comb begin
    pos_t t;
    t = '0;
    for (int i = 0; i < WAYS; i++) begin
      pos_nxt[i] = pos_cur[i];
      vld_nxt[i] = vld_cur[i];
    end
    case (op_r)
      ipvr_pkg::OP_HIT: begin
        if (in_range && vld_cur[widx]) begin
          for (int i = 0; i < WAYS; i++) begin
            if (i != int'(widx) && vld_cur[i]) begin
              if (n < p && pos_cur[i] >= n && pos_cur[i] < p) begin
                pos_nxt[i] = pos_cur[i] + 1'b1;
              end else if (n > p && pos_cur[i] > p && pos_cur[i] <= n) begin
                pos_nxt[i] = pos_cur[i] - 1'b1;
              end
            end
          end
          pos_nxt[widx] = n;
        end
      end
      ipvr_pkg::OP_FILL: begin
        if (in_range) begin
          for (int i = 0; i < WAYS; i++) begin
            if (i != int'(widx) && vld_cur[i]) begin
              // close the gap of a refilled way, then push back behind the slot
              t = (vld_cur[widx] && pos_cur[i] > p) ? pos_cur[i] - 1'b1 : pos_cur[i];
              if (t >= ins && int'(t) != MAXP) begin
                t = t + 1'b1;
              end
              pos_nxt[i] = t;
            end
          end
          vld_nxt[widx] = 1'b1;
          pos_nxt[widx] = ins;
        end
      end
      ipvr_pkg::OP_INV: begin
        if (in_range && vld_cur[widx]) begin
          for (int i = 0; i < WAYS; i++) begin
            if (i != int'(widx) && vld_cur[i] && pos_cur[i] > p) begin
              pos_nxt[i] = pos_cur[i] - 1'b1;
            end
          end
          vld_nxt[widx] = 1'b0;
          pos_nxt[widx] = '0;
        end
      end
      default: ;
    endcase
  end

  // pack the new set word for write-back
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      wdata[i*PW +: PW]   = pos_nxt[i];
      wdata[WAYS*PW + i]  = vld_nxt[i];
    end
  end

  // keep a copy of the new state for the victim search
  always_ff @(posedge clk) begin
    if (mem_we) begin
      pos_r <= pos_nxt;
      vld_r <= vld_nxt;
    end
  end

  // victim: lowest free way, else lowest way in the deepest position
  always_comb begin
    logic [WAYS-1:0] deep;
    deep        = '1;
    victim      = '0;
    victim_free = ~&vld_r;
    for (int i = 0; i < WAYS; i++) begin
      for (int j = 0; j < WAYS; j++) begin
        if (j < i && pos_r[j] >= pos_r[i]) deep[i] = 1'b0;
        if (j > i && pos_r[j] > pos_r[i])  deep[i] = 1'b0;
      end
    end
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (victim_free) begin
        if (!vld_r[i]) victim = ipvr_pkg::WAY_W'(i);
      end else if (deep[i]) begin
        victim = ipvr_pkg::WAY_W'(i);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_VIC) && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_VIC) && slot_free) begin
      out_way_r  <= victim;
      out_free_r <= victim_free;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.victim_way     = out_way_r;
  assign out_chan.victim_is_free = out_free_r;

endmodule

`default_nettype wire

@@ tb/tb_ipv_recency_replacement_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ipv_recency_replacement_unit
// Self-checking bench for the recency replacement unit. A driver feeds event
// words from a queue, and a predictor works out the victim after every
// accepted event. A monitor then compares each victim word with the oldest
// prediction. A directed opening is followed by random traffic under several
// promotion vector and insertion settings, with random idling on both sides
// and a long receiver hold-off that backs the unit up.
// ----------------------------------------------------------------------------
module tb_ipv_recency_replacement_unit;
  import ipvr_pkg::*;

  localparam int WAYS        = WAYS_DEF;
  localparam int RUN_LIMIT   = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam int MAX_SHOWN   = 10;

  // the fourth event code carries no meaning and leaves the set alone
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [WAY_W-1:0] way;
    int               gap;
  } event_word_t;

  typedef struct {
    logic [WAY_W-1:0] way;
    logic             free;
  } victim_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = CFG_PROMO;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  ipvr_in_if  in_chan ();
  ipvr_out_if out_chan ();

  ipv_recency_replacement_unit #(
    .WAYS (WAYS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // predicted set state and settings
  logic [WAY_W-1:0] way_rank [WAYS];
  logic             way_live [WAYS];
  logic [VEC_W-1:0] promo_vec;
  logic [INS_W-1:0] ins_pos;

  event_word_t event_q [$];
  victim_t     victim_q [$];
  int          queued_cnt    = 0;
  int          accepted_cnt  = 0;
  int          errors        = 0;
  int          cycle_cnt     = 0;
  int          sink_idle_pct = 0;
  int          stall_left    = 0;
  int          hold_left     = 0;
  logic        hold_arm      = 1'b0;

  // --------------------------------------------------------------------------
  // Set state predictor
  // --------------------------------------------------------------------------

  // free a valid way and close the gap behind it
  function automatic void free_way(int w);
    int p;
    int i;
    p = way_rank[w];
    for (i = 0; i < WAYS; i++) begin
      if (i != w && way_live[i] && way_rank[i] > p)
        way_rank[i] = way_rank[i] - 1'b1;
    end
    way_live[w] = 1'b0;
    way_rank[w] = '0;
  endfunction

  // move a hit way to the position its old position maps to
  function automatic void promote_way(int w);
    int p;
    int n;
    int i;
    p = way_rank[w];
    n = promo_vec[VEC_ENT_W*p +: VEC_ENT_W];
    if (n > WAYS - 1)
      n = WAYS - 1;
    for (i = 0; i < WAYS; i++) begin
      if (i != w && way_live[i]) begin
        if (n < p && way_rank[i] >= n && way_rank[i] < p)
          way_rank[i] = way_rank[i] + 1'b1;
        else if (n > p && way_rank[i] > p && way_rank[i] <= n)
          way_rank[i] = way_rank[i] - 1'b1;
      end
    end
    way_rank[w] = WAY_W'(n);
  endfunction

  // place a filled way at the insertion point, pushing the rest back
  function automatic void insert_way(int w);
    int ins;
    int i;
    int r;
    ins = ins_pos;
    if (ins > WAYS - 1)
      ins = WAYS - 1;
    if (way_live[w])
      free_way(w);
    for (i = 0; i < WAYS; i++) begin
      if (i != w && way_live[i] && way_rank[i] >= ins) begin
        r = way_rank[i] + 1;
        way_rank[i] = WAY_W'((r > WAYS - 1) ? WAYS - 1 : r);
      end
    end
    way_live[w] = 1'b1;
    way_rank[w] = WAY_W'(ins);
  endfunction

  // update the set for one event and name the next victim
  function automatic victim_t apply_event(logic [OP_W-1:0] op, logic [WAY_W-1:0] way);
    victim_t v;
    int      w;
    int      i;
    w = way;
    if (w < WAYS) begin
      case (op)
        OP_HIT:  if (way_live[w]) promote_way(w);
        OP_FILL: insert_way(w);
        OP_INV:  if (way_live[w]) free_way(w);
        default: ;
      endcase
    end
    v.way  = '0;
    v.free = 1'b0;
    for (i = WAYS - 1; i >= 0; i--) begin
      if (!way_live[i]) begin
        v.way  = WAY_W'(i);
        v.free = 1'b1;
      end
    end
    if (!v.free) begin
      for (i = 1; i < WAYS; i++) begin
        if (way_rank[i] > way_rank[v.way])
          v.way = WAY_W'(i);
      end
    end
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic int draw_idle(int pct);
    if ($urandom_range(99) < pct)
      return $urandom_range(6, 1);
    return 0;
  endfunction

  function automatic void queue_event(logic [OP_W-1:0] op, logic [WAY_W-1:0] way, int gap);
    event_word_t e;
    e.op  = op;
    e.way = way;
    e.gap = gap;
    event_q.push_back(e);
    queued_cnt++;
  endfunction

  // mostly hits and fills, with fill-then-reuse runs; some invalidates and noise
  task automatic queue_traffic(int count, int src_pct, int inv_pct);
    int               n;
    int               r;
    int               k;
    logic [WAY_W-1:0] w;
    n = 0;
    while (n < count) begin
      r = $urandom_range(99);
      w = WAY_W'($urandom_range(WAYS - 1));
      if (r < 4) begin
        queue_event(OP_SPARE, w, draw_idle(src_pct));
        n++;
      end else if (r < 4 + inv_pct) begin
        queue_event(OP_INV, w, draw_idle(src_pct));
        n++;
      end else if (r < 24 + inv_pct) begin
        // a miss: fill the way, then reuse it up to three times
        queue_event(OP_FILL, w, draw_idle(src_pct));
        for (k = $urandom_range(3); k > 0; k--)
          queue_event(OP_HIT, w, draw_idle(src_pct));
        n += 2;
      end else if (r < 40 + inv_pct) begin
        queue_event(OP_FILL, w, draw_idle(src_pct));
        n++;
      end else begin
        queue_event(OP_HIT, w, draw_idle(src_pct));
        n++;
      end
    end
  endtask

  // hold until every queued word has gone in and every victim word has come out
  task automatic wait_drain();
    while (accepted_cnt != queued_cnt || victim_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(logic [VEC_W-1:0] vec, logic [INS_W-1:0] ins);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_PROMO;
    cfg_wdata <= vec;
    @(posedge clk);
    cfg_idx   <= CFG_INS;
    cfg_wdata <= CFG_DAT_W'(ins);
    @(posedge clk);
    cfg_we    <= 1'b0;
    promo_vec = vec;
    ins_pos   = ins;
  endtask

  task automatic run_phase(logic [VEC_W-1:0] vec, logic [INS_W-1:0] ins,
                           int count, int src_pct, int snk_pct, int inv_pct);
    set_config(vec, ins);
    sink_idle_pct = snk_pct;
    queue_traffic(count, src_pct, inv_pct);
    wait_drain();
  endtask

  // --------------------------------------------------------------------------
  // Driver: offer queued event words, predict on each acceptance
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    event_word_t e;
    logic        offer;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      in_chan.op    <= OP_HIT;
      in_chan.way   <= '0;
    end else begin
      offer = in_chan.valid;
      if (in_chan.valid && in_chan.ready) begin
        victim_q.push_back(apply_event(in_chan.op, in_chan.way));
        accepted_cnt++;
        offer = 1'b0;
      end
      // count down the gap in front of the next word, then present it
      if (!offer && event_q.size() > 0) begin
        if (event_q[0].gap > 0) begin
          event_q[0].gap = event_q[0].gap - 1;
        end else begin
          e = event_q.pop_front();
          in_chan.op  <= e.op;
          in_chan.way <= e.way;
          offer = 1'b1;
        end
      end
      in_chan.valid <= offer;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: take victim words with random stalls and check them
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    victim_t want;
    logic    take;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      stall_left = 0;
    end else begin
      take = 1'b1;
      if (out_chan.valid && out_chan.ready) begin
        if (victim_q.size() == 0) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("%0t: victim word with none outstanding: way %0d free %0b",
                     $realtime, out_chan.victim_way, out_chan.victim_is_free);
        end else begin
          want = victim_q.pop_front();
          if (out_chan.victim_way !== want.way || out_chan.victim_is_free !== want.free) begin
            errors++;
            if (errors <= MAX_SHOWN)
              $display("%0t: victim mismatch: expected way %0d free %0b, got way %0d free %0b",
                       $realtime, want.way, want.free,
                       out_chan.victim_way, out_chan.victim_is_free);
          end
        end
        stall_left = draw_idle(sink_idle_pct);
        take = (stall_left == 0);
      end else if (stall_left > 0) begin
        stall_left--;
        take = (stall_left == 0);
      end
      if (hold_left != 0)
        take = 1'b0;
      out_chan.ready <= take;
    end
  end

  // long receiver hold-off, counted on its own
  always @(posedge clk) begin
    if (!rst_n)
      hold_left <= 0;
    else if (hold_arm)
      hold_left <= HOLD_CYCLES;
    else if (hold_left > 0)
      hold_left <= hold_left - 1;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == RUN_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    int i;
    in_chan.valid  = 1'b0;
    in_chan.op     = OP_HIT;
    in_chan.way    = '0;
    out_chan.ready = 1'b0;
    promo_vec      = '0;
    ins_pos        = '0;
    for (i = 0; i < WAYS; i++) begin
      way_rank[i] = '0;
      way_live[i] = 1'b0;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed opening under reset settings: ignored events on an empty set,
    // a full set with all fills at the front, refill, double invalidate
    queue_event(OP_HIT,   3'd0, 0);
    queue_event(OP_INV,   3'd3, 0);
    queue_event(OP_SPARE, 3'd7, 0);
    for (i = 0; i < WAYS; i++)
      queue_event(OP_FILL, WAY_W'(i), 0);
    queue_event(OP_HIT,   3'd0, 0);
    queue_event(OP_HIT,   3'd7, 0);
    queue_event(OP_FILL,  3'd2, 0);
    queue_event(OP_INV,   3'd4, 0);
    queue_event(OP_INV,   3'd4, 0);
    queue_event(OP_SPARE, 3'd0, 0);
    queue_event(OP_FILL,  3'd4, 0);
    queue_event(OP_INV,   3'd0, 0);
    queue_event(OP_INV,   3'd7, 0);
    wait_drain();

    // extremes: all-ones vector with deepest insertion, then plain MRU scheme
    run_phase(24'hFFFFFF, 3'd7, 200, 30, 30, 10);
    run_phase('0, '0, 200, 0, 0, 8);
    // identity vector: hits never move anything
    run_phase(24'o76543210, 3'd4, 200, 50, 50, 6);
    // insert at the back, promote to the front
    run_phase('0, 3'd7, 200, 20, 60, 12);

    // back the unit up behind a stalled receiver, then let it drain
    hold_arm <= 1'b1;
    @(posedge clk);
    hold_arm <= 1'b0;
    queue_traffic(40, 0, 8);
    wait_drain();

    for (i = 0; i < 3; i++)
      run_phase(VEC_W'($urandom), INS_W'($urandom_range(7)), 180, 25 * i, 60 - 25 * i,
                4 * i + 4);

    wait_drain();
    repeat (10) @(posedge clk);
    if (victim_q.size() != 0)
      errors++;
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
